// ===== rtl/bsm_pkg.sv =====
// ----------------------------------------------------------------------------
// bsm_pkg
// Shared types and constants of the bank switch mapper: request and target
// codes, the beat layouts and the work RAM geometry.
// ----------------------------------------------------------------------------
package bsm_pkg;

    localparam int WORK_RAM_BYTES = 8192;
    localparam int MAX_PRG_BANKS  = 64;
    localparam int RAM_AW         = $clog2(WORK_RAM_BYTES);

    // Reset value of the PRG bank count register.
    localparam logic [6:0] PRG_BANK_COUNT_RST = 7'd64;

    typedef enum logic [2:0] {
        REQ_CPU_WRITE = 3'd0,
        REQ_CPU_READ  = 3'd1,
        REQ_PPU_READ  = 3'd2,
        REQ_LINE_TICK = 3'd3,
        REQ_IRQ_ACK   = 3'd4
    } t_req;

    typedef enum logic [1:0] {
        TGT_NONE = 2'd0,
        TGT_PRG  = 2'd1,
        TGT_RAM  = 2'd2,
        TGT_CHR  = 2'd3
    } t_target;

    // Upper three CPU address bits: the 8 KB window of an access.
    typedef enum logic [2:0] {
        WIN_RAM   = 3'd3,
        WIN_BANK  = 3'd4,
        WIN_MIRR  = 3'd5,
        WIN_LINE  = 3'd6,
        WIN_IRQ   = 3'd7
    } t_window;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [15:0] bus_addr;
        logic [7:0]  write_data;
    } t_req_beat;

    // Result of one item apart from the work RAM byte.
    typedef struct packed {
        t_target     target;
        logic [18:0] mapped_addr;
        logic        irq_pending;
        logic        mirror_horizontal;
    } t_meta;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [RAM_AW-1:0] addr;
        logic [7:0]        wdata;
    } t_ram_cmd;

endpackage

// ===== rtl/bsm_if.sv =====
// ----------------------------------------------------------------------------
// bsm_if
// Valid/ready channels of the mapper: request beats, result beats and the
// bank count configuration write.
// ----------------------------------------------------------------------------
interface bsm_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [15:0] bus_addr;
    logic [7:0]  write_data;

    modport source (output valid, req_type, bus_addr, write_data, input ready);
    modport sink   (input valid, req_type, bus_addr, write_data, output ready);
endinterface

interface bsm_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  target;
    logic [18:0] mapped_addr;
    logic [7:0]  ram_data;
    logic        irq_pending;
    logic        mirror_horizontal;

    modport source (output valid, target, mapped_addr, ram_data, irq_pending,
                    mirror_horizontal, input ready);
    modport sink   (input valid, target, mapped_addr, ram_data, irq_pending,
                    mirror_horizontal, output ready);
endinterface

interface bsm_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] prg_bank_count;

    modport source (output valid, prg_bank_count, input ready);
    modport sink   (input valid, prg_bank_count, output ready);
endinterface

// ===== rtl/bsm_ram.sv =====
// ----------------------------------------------------------------------------
// bsm_ram
// Work RAM: single port synchronous memory with a registered read. The read
// data holds until the next read is issued.
// ----------------------------------------------------------------------------
module bsm_ram (
    input  logic              i_clk,
    input  bsm_pkg::t_ram_cmd i_cmd,
    output logic [7:0]        o_rdata
);

    logic [7:0] r_mem [bsm_pkg::WORK_RAM_BYTES];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_mem[i_cmd.addr] <= i_cmd.wdata;
        end
        if (i_cmd.re) begin
            r_rdata <= r_mem[i_cmd.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/bsm_ctrl.sv =====
// ----------------------------------------------------------------------------
// bsm_ctrl
// Mapper register file and scanline counter. Decodes each accepted item,
// updates the registers, works out the ROM mapping and issues the work RAM
// access.
// ----------------------------------------------------------------------------
module bsm_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  bsm_pkg::t_req_beat  i_req,
    input  logic [6:0]          i_bank_count,
    output bsm_pkg::t_meta      o_meta,
    output bsm_pkg::t_ram_cmd   o_ram
);

    logic [7:0] r_bank [8];
    logic [2:0] r_tgt_idx;
    logic       r_prg_swap;
    logic       r_chr_inv;
    logic       r_mirror;
    logic [7:0] r_line_cnt;
    logic [7:0] r_line_rld;
    logic       r_irq_en;
    logic       r_irq_flag;

    logic [2:0] n_tgt_idx;
    logic       n_prg_swap;
    logic       n_chr_inv;
    logic       n_mirror;
    logic [7:0] n_line_cnt;
    logic [7:0] n_line_rld;
    logic       n_irq_en;
    logic       n_irq_flag;
    logic       bank_we;

    logic [15:0] addr;
    logic [7:0]  wdata;
    logic        odd;
    logic [2:0]  win;
    logic [6:0]  n_banks;
    logic [1:0]  slot;
    logic [5:0]  prg_bank;
    logic [18:0] prg_addr;
    logic [12:0] chr_off;
    logic [7:0]  chr_reg;
    logic [18:0] chr_addr;
    logic [7:0]  cnt_after;

    assign addr  = i_req.bus_addr;
    assign wdata = i_req.write_data;
    assign odd   = addr[0];
    assign win   = addr[15:13];

    // PRG mapping, live from the registers.
    always_comb begin
        if (i_bank_count < 7'd2) begin
            n_banks = 7'd2;
        end else if (32'(i_bank_count) > bsm_pkg::MAX_PRG_BANKS) begin
            n_banks = 7'(bsm_pkg::MAX_PRG_BANKS);
        end else begin
            n_banks = i_bank_count;
        end
        slot = addr[14:13];
        if (slot == 2'd1) begin
            prg_bank = r_bank[7][5:0];
        end else if (slot == 2'd3) begin
            prg_bank = 6'(n_banks - 7'd1);
        end else if ((slot == 2'd0) == (r_prg_swap == 1'b0)) begin
            prg_bank = r_bank[6][5:0];
        end else begin
            prg_bank = 6'(n_banks - 7'd2);
        end
        prg_addr = {prg_bank, addr[12:0]};
    end

    // CHR mapping: two 2 KB banks in one 4 KB half, four 1 KB banks in the other.
    always_comb begin
        chr_off = addr[12:0] ^ {r_chr_inv, 12'd0};
        if (!chr_off[12]) begin
            chr_reg  = r_bank[{2'd0, chr_off[11]}];
            chr_addr = {1'b0, chr_reg[7:1], chr_off[10:0]};
        end else begin
            chr_reg  = r_bank[3'd2 + {1'b0, chr_off[11:10]}];
            chr_addr = {1'b0, chr_reg, chr_off[9:0]};
        end
    end

    assign cnt_after = (r_line_cnt == 8'd0) ? r_line_rld : r_line_cnt - 8'd1;

    always_comb begin
        n_tgt_idx  = r_tgt_idx;
        n_prg_swap = r_prg_swap;
        n_chr_inv  = r_chr_inv;
        n_mirror   = r_mirror;
        n_line_cnt = r_line_cnt;
        n_line_rld = r_line_rld;
        n_irq_en   = r_irq_en;
        n_irq_flag = r_irq_flag;
        bank_we    = 1'b0;
        o_ram      = '0;
        o_ram.addr  = bsm_pkg::RAM_AW'(32'(addr[12:0]) % bsm_pkg::WORK_RAM_BYTES);
        o_ram.wdata = wdata;
        o_meta.target      = bsm_pkg::TGT_NONE;
        o_meta.mapped_addr = '0;
        case (i_req.req_type)
            bsm_pkg::REQ_CPU_WRITE: begin
                case (win)
                    bsm_pkg::WIN_RAM: begin
                        o_ram.we = i_accept;
                    end
                    bsm_pkg::WIN_BANK: begin
                        if (!odd) begin
                            n_tgt_idx  = wdata[2:0];
                            n_prg_swap = wdata[6];
                            n_chr_inv  = wdata[7];
                        end else begin
                            bank_we = 1'b1;
                        end
                    end
                    bsm_pkg::WIN_MIRR: begin
                        if (!odd) begin
                            n_mirror = wdata[0];
                        end
                    end
                    bsm_pkg::WIN_LINE: begin
                        if (!odd) begin
                            n_line_rld = wdata;
                        end else begin
                            n_line_cnt = 8'd0;
                        end
                    end
                    bsm_pkg::WIN_IRQ: begin
                        if (!odd) begin
                            n_irq_en   = 1'b0;
                            n_irq_flag = 1'b0;
                        end else begin
                            n_irq_en = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            bsm_pkg::REQ_CPU_READ: begin
                if (addr[15]) begin
                    o_meta.target      = bsm_pkg::TGT_PRG;
                    o_meta.mapped_addr = prg_addr;
                end else if (win == bsm_pkg::WIN_RAM) begin
                    o_meta.target = bsm_pkg::TGT_RAM;
                    o_ram.re      = i_accept;
                end
            end
            bsm_pkg::REQ_PPU_READ: begin
                if (addr[15:13] == 3'd0) begin
                    o_meta.target      = bsm_pkg::TGT_CHR;
                    o_meta.mapped_addr = chr_addr;
                end
            end
            bsm_pkg::REQ_LINE_TICK: begin
                n_line_cnt = cnt_after;
                if (cnt_after == 8'd0 && r_irq_en) begin
                    n_irq_flag = 1'b1;
                end
            end
            bsm_pkg::REQ_IRQ_ACK: begin
                n_irq_flag = 1'b0;
            end
            default: begin
            end
        endcase
        o_meta.irq_pending       = n_irq_flag;
        o_meta.mirror_horizontal = n_mirror;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                r_bank[i] <= 8'd0;
            end
            r_tgt_idx  <= 3'd0;
            r_prg_swap <= 1'b0;
            r_chr_inv  <= 1'b0;
            r_mirror   <= 1'b1;
            r_line_cnt <= 8'd0;
            r_line_rld <= 8'd0;
            r_irq_en   <= 1'b0;
            r_irq_flag <= 1'b0;
        end else if (i_accept) begin
            if (bank_we) begin
                r_bank[r_tgt_idx] <= wdata;
            end
            r_tgt_idx  <= n_tgt_idx;
            r_prg_swap <= n_prg_swap;
            r_chr_inv  <= n_chr_inv;
            r_mirror   <= n_mirror;
            r_line_cnt <= n_line_cnt;
            r_line_rld <= n_line_rld;
            r_irq_en   <= n_irq_en;
            r_irq_flag <= n_irq_flag;
        end
    end

endmodule

// ===== rtl/bank_switch_mapper_with_line_irq.sv =====
// ----------------------------------------------------------------------------
// bank_switch_mapper_with_line_irq
// Cartridge bank switching mapper with scanline interrupt counter and work RAM.
// ----------------------------------------------------------------------------
// Usage: request beats arrive on i_req (CPU write, CPU read, PPU pattern read,
// scanline tick or interrupt acknowledge). Each request gives exactly one
// result beat on o_res: a banked PRG or CHR ROM byte address, or a work RAM
// byte, together with the interrupt and mirroring levels after the request.
// The number of PRG banks is written on i_cfg, which is always ready; it is
// meant to be written only while no request is in flight.
// A result passes through the RAM stage, which holds the registered work RAM
// read, and then the output register before it is valid on o_res.
// Throughput is one request per cycle while the receiver takes results, set by
// the single work RAM port, which is used once per request.
// A synchronous active-low reset clears the bank registers, modes, counter and
// interrupt, selects horizontal mirroring and sets the bank count to 64. The
// work RAM contents are not cleared.
// If the receiver stalls, the output register holds its beat and one further
// request can still be taken into the RAM stage; after that i_req.ready falls.
// ----------------------------------------------------------------------------
module bank_switch_mapper_with_line_irq (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bsm_cfg_if.sink   i_cfg,
    bsm_req_if.sink   i_req,
    bsm_res_if.source o_res
);

    logic [6:0]          r_prg_bank_count;
    logic                r_s1_valid;
    bsm_pkg::t_meta      r_s1_meta;
    logic                r_s2_valid;
    bsm_pkg::t_meta      r_s2_meta;
    logic [7:0]          r_s2_ram_data;

    bsm_pkg::t_req_beat  req;
    bsm_pkg::t_meta      meta;
    bsm_pkg::t_ram_cmd   ram_cmd;
    logic [7:0]          ram_rdata;
    logic                s1_move;
    logic                in_accept;

    // Configuration is a plain register write with no back-pressure.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_bank_count <= bsm_pkg::PRG_BANK_COUNT_RST;
        end else if (i_cfg.valid) begin
            r_prg_bank_count <= i_cfg.prg_bank_count;
        end
    end

    assign req.req_type   = i_req.req_type;
    assign req.bus_addr   = i_req.bus_addr;
    assign req.write_data = i_req.write_data;

    // The RAM stage moves on whenever the output register is empty or its
    // beat is being taken this cycle.
    assign s1_move     = !r_s2_valid || o_res.ready;
    assign i_req.ready = !r_s1_valid || s1_move;
    assign in_accept   = i_req.valid && i_req.ready;

    bsm_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_req        (req),
        .i_bank_count (r_prg_bank_count),
        .o_meta       (meta),
        .o_ram        (ram_cmd)
    );

    // A RAM write and a later read of the same byte are always issued at
    // different edges, so the read sees the written data without forwarding.
    // The read data holds until the next read, which keeps it safe while the
    // RAM stage waits on a stalled output.
    bsm_ram u_ram (
        .i_clk   (i_clk),
        .i_cmd   (ram_cmd),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (i_req.ready) begin
                r_s1_valid <= i_req.valid;
            end
            if (s1_move) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_meta <= meta;
        end
        if (s1_move && r_s1_valid) begin
            r_s2_meta     <= r_s1_meta;
            r_s2_ram_data <= (r_s1_meta.target == bsm_pkg::TGT_RAM) ? ram_rdata : 8'd0;
        end
    end

    assign o_res.valid             = r_s2_valid;
    assign o_res.target            = r_s2_meta.target;
    assign o_res.mapped_addr       = r_s2_meta.mapped_addr;
    assign o_res.ram_data          = r_s2_ram_data;
    assign o_res.irq_pending       = r_s2_meta.irq_pending;
    assign o_res.mirror_horizontal = r_s2_meta.mirror_horizontal;

endmodule
